// File: design/tce_pkg.sv
// ----------------------------------------------------------------------------
// tce_pkg: shared types and constants of the text console engine
// Holds the command item and result layouts, the operation codes, the
// character and scancode constants, and the controller/datapath link.
// ----------------------------------------------------------------------------
`default_nettype none

package tce_pkg;

  // Operation codes of the command item.
  localparam logic [2:0] OP_PRINT     = 3'd0;
  localparam logic [2:0] OP_BACKSPACE = 3'd1;
  localparam logic [2:0] OP_ARROW     = 3'd2;
  localparam logic [2:0] OP_SET       = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;
  localparam logic [2:0] OP_WRITE     = 3'd5;
  localparam logic [2:0] OP_READ      = 3'd6;

  // Arrow-key scancodes.
  localparam logic [7:0] KEY_UP    = 8'h48;
  localparam logic [7:0] KEY_DOWN  = 8'h50;
  localparam logic [7:0] KEY_LEFT  = 8'h4B;
  localparam logic [7:0] KEY_RIGHT = 8'h4D;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] character;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] attribute;
  } item_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_offset;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        scrolled;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic calc;
    logic exec;
    logic fill_step;
    logic copy_step;
    logic blank_start;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       scroll;
    logic       ptr_last;
  } stat_t;

endpackage

`default_nettype wire

// File: design/tce_ctrl.sv
// ----------------------------------------------------------------------------
// tce_ctrl: command sequencer of the text console engine
// Steps each item through address calculation, execution, the optional
// scroll or clear sweep, and the result cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire tce_pkg::stat_t stat,
  output tce_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CALC,
    S_EXEC,
    S_COPY,
    S_DRAIN,
    S_FILL,
    S_FINISH
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_INIT:   if (stat.ptr_last) state_next = S_IDLE;
      S_IDLE:   if (start) state_next = S_CALC;
      S_CALC:   state_next = S_EXEC;
      S_EXEC: begin
        if (stat.op == tce_pkg::OP_CLEAR) begin
          state_next = S_FILL;
        end else if (stat.scroll) begin
          state_next = S_COPY;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_COPY:   if (stat.ptr_last) state_next = S_DRAIN;
      S_DRAIN:  state_next = S_FILL;
      S_FILL:   if (stat.ptr_last) state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.capture     = (state == S_IDLE) && start;
    cmd.calc        = (state == S_CALC);
    cmd.exec        = (state == S_EXEC);
    cmd.fill_step   = (state == S_INIT) || (state == S_FILL);
    cmd.copy_step   = (state == S_COPY);
    cmd.blank_start = (state == S_DRAIN);
    cmd.finish      = (state == S_FINISH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// File: design/tce_datapath.sv
// ----------------------------------------------------------------------------
// tce_datapath: cell buffer, cursor and result registers
// Holds the character/attribute buffer with one write and one read port,
// the cursor, the sweep pointer used by clear and scroll, and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_wdata,
  input  wire tce_pkg::item_t   item,
  input  wire tce_pkg::cmd_t    cmd,
  output tce_pkg::stat_t        stat,
  output tce_pkg::result_t      result,
  output logic                  done
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  tce_pkg::item_t itm;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [7:0]    def_attr;
  logic [7:0]    fill_attr;
  logic [AW-1:0] ptr;
  logic [AW-1:0] addr;
  logic [AW-1:0] pw_addr;
  logic          pw_valid;
  logic          in_range;
  logic          rd_sel;
  logic          scrolled;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata;

  logic          in_range_c;
  logic [CW-1:0] sel_col;
  logic [RW-1:0] sel_row;
  logic [15:0]   addr16;
  logic [15:0]   off16;
  logic [15:0]   col16;
  logic [15:0]   row16;
  logic          at_last_col;
  logic          at_last_row;
  logic          is_nl;
  logic          print_wrap;
  logic          need_scroll;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  assign in_range_c  = (itm.column < 8'(COLUMNS)) && (itm.row < 8'(ROWS));
  assign at_last_col = (cur_col == CW'(COLUMNS - 1));
  assign at_last_row = (cur_row == RW'(ROWS - 1));
  assign is_nl       = (itm.character == tce_pkg::NEWLINE_CODE);
  assign print_wrap  = is_nl || at_last_col;
  assign need_scroll = (itm.operation == tce_pkg::OP_PRINT) && print_wrap && at_last_row;

  // Cell that the command touches; backspace targets the cell it moves onto.
  always_comb begin
    case (itm.operation)
      tce_pkg::OP_PRINT: begin
        sel_col = cur_col;
        sel_row = cur_row;
      end
      tce_pkg::OP_BACKSPACE: begin
        if (cur_col != '0) begin
          sel_col = cur_col - CW'(1);
          sel_row = cur_row;
        end else begin
          sel_col = CW'(COLUMNS - 1);
          sel_row = cur_row - RW'(1);
        end
      end
      default: begin
        sel_col = itm.column[CW-1:0];
        sel_row = itm.row[RW-1:0];
      end
    endcase
  end

  assign addr16 = 16'(sel_row) * 16'(COLUMNS) + 16'(sel_col);
  assign col16  = 16'(cur_col);
  assign row16  = 16'(cur_row);
  assign off16  = row16 * 16'(COLUMNS) + col16;

  // Write port: sweeps first, then the trailing copy write, then the command.
  always_comb begin
    we    = 1'b0;
    waddr = addr;
    wdata = {def_attr, itm.character};
    if (cmd.fill_step) begin
      we    = 1'b1;
      waddr = ptr;
      wdata = {fill_attr, tce_pkg::BLANK_CODE};
    end else if (pw_valid) begin
      we    = 1'b1;
      waddr = pw_addr;
      wdata = rdata;
    end else if (cmd.exec) begin
      case (itm.operation)
        tce_pkg::OP_PRINT: begin
          we = !is_nl;
        end
        tce_pkg::OP_BACKSPACE: begin
          we    = (cur_col != '0) || (cur_row != '0);
          wdata = {def_attr, tce_pkg::BLANK_CODE};
        end
        tce_pkg::OP_WRITE: begin
          we    = in_range;
          wdata = {itm.attribute, itm.character};
        end
        default: we = 1'b0;
      endcase
    end
  end

  assign re    = cmd.copy_step ||
                 (cmd.exec && (itm.operation == tce_pkg::OP_READ) && in_range);
  assign raddr = cmd.copy_step ? ptr : addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      def_attr <= tce_pkg::RESET_ATTR;
    end else if (cfg_we) begin
      def_attr <= cfg_wdata;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_row   <= '0;
      ptr       <= '0;
      fill_attr <= tce_pkg::RESET_ATTR;
      pw_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      done     <= cmd.finish;
      pw_valid <= cmd.copy_step;
      if (cmd.fill_step || cmd.copy_step) begin
        ptr <= ptr + AW'(1);
      end
      if (cmd.blank_start) begin
        ptr       <= AW'(CELLS - COLUMNS);
        fill_attr <= def_attr;
      end
      if (cmd.exec) begin
        case (itm.operation)
          tce_pkg::OP_PRINT: begin
            if (print_wrap) begin
              cur_col <= '0;
              if (!at_last_row) begin
                cur_row <= cur_row + RW'(1);
              end
            end else begin
              cur_col <= cur_col + CW'(1);
            end
          end
          tce_pkg::OP_BACKSPACE: begin
            if (cur_col != '0) begin
              cur_col <= cur_col - CW'(1);
            end else if (cur_row != '0) begin
              cur_col <= CW'(COLUMNS - 1);
              cur_row <= cur_row - RW'(1);
            end
          end
          tce_pkg::OP_ARROW: begin
            if (itm.character == tce_pkg::KEY_UP && cur_row != '0) begin
              cur_row <= cur_row - RW'(1);
            end else if (itm.character == tce_pkg::KEY_DOWN && !at_last_row) begin
              cur_row <= cur_row + RW'(1);
            end else if (itm.character == tce_pkg::KEY_LEFT && cur_col != '0) begin
              cur_col <= cur_col - CW'(1);
            end else if (itm.character == tce_pkg::KEY_RIGHT && !at_last_col) begin
              cur_col <= cur_col + CW'(1);
            end
          end
          tce_pkg::OP_SET: begin
            if (in_range) begin
              cur_col <= itm.column[CW-1:0];
              cur_row <= itm.row[RW-1:0];
            end
          end
          tce_pkg::OP_CLEAR: begin
            cur_col   <= '0;
            cur_row   <= '0;
            ptr       <= '0;
            fill_attr <= def_attr;
          end
          default: ;
        endcase
        if (need_scroll) begin
          ptr <= AW'(COLUMNS);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      itm <= item;
    end
    if (cmd.calc) begin
      addr     <= addr16[AW-1:0];
      in_range <= in_range_c;
    end
    if (cmd.exec) begin
      rd_sel   <= (itm.operation == tce_pkg::OP_READ) && in_range;
      scrolled <= need_scroll;
    end
    if (cmd.copy_step) begin
      pw_addr <= ptr - AW'(COLUMNS);
    end
    if (cmd.finish) begin
      result.cursor_column <= col16[6:0];
      result.cursor_row    <= row16[4:0];
      result.cursor_offset <= off16[10:0];
      result.read_char     <= rd_sel ? rdata[7:0] : 8'h00;
      result.read_attr     <= rd_sel ? rdata[15:8] : 8'h00;
      result.scrolled      <= scrolled;
    end
  end

  assign stat.op       = itm.operation;
  assign stat.scroll   = need_scroll;
  assign stat.ptr_last = (ptr == AW'(CELLS - 1));

endmodule

`default_nettype wire

// File: design/text_console_engine.sv
// ----------------------------------------------------------------------------
// text_console_engine: character-cell text console with cursor
// Keeps a COLUMNS x ROWS buffer of character/attribute cells and a cursor,
// and executes one console command per item.
// ----------------------------------------------------------------------------
// A command item on item is taken at a rising edge where start is high and
// busy is low. Exactly one result follows, valid on result for the single
// cycle in which done is high; the receiver cannot stall, so it takes the
// result whenever done is seen. cfg_we/cfg_wdata write the default attribute;
// the user must write it only while no command is in flight, as the block
// does not enforce this. The attribute colors printed characters and every
// blank cell made by clear, scroll and backspace.
// Most commands pass through address calculation, execution and the result
// register, and the next item is taken at the edge that ends the done cycle.
// A clear sweeps the buffer one cell per cycle. A print that scrolls copies
// the buffer up one row through the single read and write port, then blanks
// the last row.
// rst (synchronous) homes the cursor, sets the default attribute to 7 and
// starts a clearing pass over the whole buffer in attribute 7; busy stays
// high during it.
`default_nettype none

module text_console_engine #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire tce_pkg::item_t   item,
  output logic                  done,
  output tce_pkg::result_t      result,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_wdata
);

  tce_pkg::cmd_t  cmd;
  tce_pkg::stat_t stat;

  // The sequencer decides which datapath step runs in each cycle.
  tce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath owns the cell buffer, cursor and result register.
  tce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result),
    .done      (done)
  );

  // A result only ever closes a command that was in flight.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("done without a command in flight");

  // An accepted item keeps the engine busy in the following cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not make the engine busy");

  // One result per command: the result strobe is never held high.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

// File: test/tce_checker.sv
// ----------------------------------------------------------------------------
// tce_checker: result predictor and scoreboard for the text console engine
// Keeps its own copy of the cell buffer, the cursor and the default
// attribute. It predicts the result of every accepted command item and
// compares each result that the block strobes out with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tce_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire tce_pkg::item_t   item,
  input  wire logic             done,
  input  wire tce_pkg::result_t result,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_wdata,
  output int                    errors,
  output int                    pending
);
  import tce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  logic [15:0] screen [CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [7:0]  blank_attr;
  result_t     console_reports [$];

  function automatic logic [15:0] blank_cell();
    return {blank_attr, BLANK_CODE};
  endfunction

  function automatic void put_cell(input int unsigned col, input int unsigned row,
                                   input logic [7:0] ch, input logic [7:0] at);
    if (col < COLUMNS && row < ROWS) begin
      screen[row * COLUMNS + col] = {at, ch};
    end
  endfunction

  function automatic void wipe_mirror();
    for (int i = 0; i < CELLS; i++) begin
      screen[i] = blank_cell();
    end
  endfunction

  function automatic void shift_rows_up();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      screen[i] = screen[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      screen[i] = blank_cell();
    end
  endfunction

  // Applies one command to the mirrored console and returns its result.
  function automatic result_t run_console_command(input item_t cmd);
    result_t     rep;
    bit          in_range;
    int unsigned offset;
    rep = '0;
    in_range = (cmd.column < COLUMNS) && (cmd.row < ROWS);
    case (cmd.operation)
      OP_PRINT: begin
        if (cmd.character == NEWLINE_CODE) begin
          cur_col = 0;
          cur_row++;
        end else begin
          put_cell(cur_col, cur_row, cmd.character, blank_attr);
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
        if (cur_row >= ROWS) begin
          shift_rows_up();
          rep.scrolled = 1'b1;
          cur_row = ROWS - 1;
        end
      end
      OP_BACKSPACE: begin
        if (cur_col > 0) begin
          cur_col--;
          put_cell(cur_col, cur_row, BLANK_CODE, blank_attr);
        end else if (cur_row > 0) begin
          cur_col = COLUMNS - 1;
          cur_row--;
          put_cell(cur_col, cur_row, BLANK_CODE, blank_attr);
        end
      end
      OP_ARROW: begin
        if (cmd.character == KEY_UP && cur_row > 0) begin
          cur_row--;
        end else if (cmd.character == KEY_DOWN && cur_row < ROWS - 1) begin
          cur_row++;
        end else if (cmd.character == KEY_LEFT && cur_col > 0) begin
          cur_col--;
        end else if (cmd.character == KEY_RIGHT && cur_col < COLUMNS - 1) begin
          cur_col++;
        end
      end
      OP_SET: begin
        if (in_range) begin
          cur_col = cmd.column;
          cur_row = cmd.row;
        end
      end
      OP_CLEAR: begin
        wipe_mirror();
        cur_col = 0;
        cur_row = 0;
      end
      OP_WRITE: begin
        put_cell(cmd.column, cmd.row, cmd.character, cmd.attribute);
      end
      OP_READ: begin
        if (in_range) begin
          {rep.read_attr, rep.read_char} = screen[cmd.row * COLUMNS + cmd.column];
        end
      end
      default: begin
      end
    endcase
    offset = cur_row * COLUMNS + cur_col;
    rep.cursor_column = cur_col[6:0];
    rep.cursor_row    = cur_row[4:0];
    rep.cursor_offset = offset[10:0];
    return rep;
  endfunction

  function automatic void check_field(input string name, input logic [10:0] want,
                                      input logic [10:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      blank_attr = RESET_ATTR;
      cur_col = 0;
      cur_row = 0;
      wipe_mirror();
      console_reports.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (console_reports.size() == 0) begin
          errors++;
          $display("%0t: result with no command outstanding, expected none, got %h",
                   $time, result);
        end else begin
          want = console_reports.pop_front();
          check_field("cursor_column", want.cursor_column, result.cursor_column);
          check_field("cursor_row", want.cursor_row, result.cursor_row);
          check_field("cursor_offset", want.cursor_offset, result.cursor_offset);
          check_field("read_char", want.read_char, result.read_char);
          check_field("read_attr", want.read_attr, result.read_attr);
          check_field("scrolled", want.scrolled, result.scrolled);
        end
      end
      if (cfg_we) begin
        blank_attr = cfg_wdata;
      end
      if (start && !busy) begin
        console_reports.push_back(run_console_command(item));
      end
    end
    pending = console_reports.size();
  end

endmodule

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the text console engine
// Drives command items into the console in random bursts, writes the default
// attribute between phases, and leaves prediction and comparison to the
// checker that sits beside the block. A short directed part covers the edges
// of the screen, scrolling and every command before the random phases start.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import tce_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  // A clear or a scrolling print keeps the block quiet while it sweeps the
  // whole buffer; the limit on quiet cycles must exceed that sweep.
  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 340;

  // The operation field has room for one code that the block treats as a
  // no-operation; it is named here since the package does not name it.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       start     = 1'b0;
  item_t      item      = '0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic       busy;
  logic       done;
  result_t    result;
  int         errors;
  int         pending;
  int         quiet_cycles = 0;

  // Command items waiting to be driven, filled one phase at a time.
  item_t command_queue [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  tce_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) console_checker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .errors   (errors),
    .pending  (pending)
  );

  // The watchdog restarts its count on every accepted item and every result.
  // Reaching the limit means the block has hung or lost a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly a position on the screen, sometimes any byte at all, so that
  // the out-of-range paths and the high bits of the fields are exercised.
  function automatic logic [7:0] pick_coord(input int span);
    if ($urandom_range(0, 4) != 0) begin
      return 8'($urandom_range(0, span - 1));
    end
    return any_byte();
  endfunction

  function automatic item_t make_cmd(input logic [2:0] op, input logic [7:0] ch,
                                     input logic [7:0] col, input logic [7:0] row,
                                     input logic [7:0] at);
    item_t cmd;
    cmd.operation = op;
    cmd.character = ch;
    cmd.column    = col;
    cmd.row       = row;
    cmd.attribute = at;
    return cmd;
  endfunction

  // Drives every queued item. The sender works in bursts: inside a burst
  // start stays high and the next item follows as soon as the previous one
  // is taken, and between bursts start drops for a random number of cycles.
  // Some bursts follow each other with no gap at all. The task is entered
  // and left right after a falling edge.
  task automatic play_commands();
    int burst_left;
    burst_left = 0;
    while (command_queue.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 15)) @(negedge clk);
        end
      end
      item  <= command_queue.pop_front();
      start <= 1'b1;
      // The item is taken at the first rising edge that finds busy low.
      do @(posedge clk); while (busy);
      @(negedge clk);
      burst_left--;
    end
    start <= 1'b0;
  endtask

  // The register is written only while the block is idle and every
  // expected result has come back.
  task automatic write_attribute(input logic [7:0] value);
    while (pending != 0 || busy) @(negedge clk);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [7:0] phase_attr [5];
    logic [7:0] arrow_keys [4];
    logic [7:0] spot_col [6];
    logic [7:0] spot_row [6];
    logic [7:0] ch;
    logic [2:0] op;
    int         anchor_col;
    int         anchor_row;
    int         run_len;
    int         pick;

    // Both extremes of the attribute are used, plus two random settings and 8'h5A.
    phase_attr = '{8'h00, 8'hFF, any_byte(), any_byte(), 8'h5A};
    arrow_keys = '{KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The block clears its buffer after reset; wait until it is ready.
    while (busy !== 1'b0) @(negedge clk);

    // Directed part, run with the attribute left at its reset value.
    // A freshly reset screen reads as blanks in the reset attribute.
    command_queue.push_back(make_cmd(OP_READ, any_byte(), 8'd0, 8'd0, any_byte()));
    // All-ones character and attribute in the bottom-right corner.
    command_queue.push_back(make_cmd(OP_WRITE, 8'hFF, 8'(COLUMNS - 1), 8'(ROWS - 1),
                                     8'hFF));
    command_queue.push_back(make_cmd(OP_READ, any_byte(), 8'(COLUMNS - 1), 8'(ROWS - 1),
                                     any_byte()));
    // Writes just past the right and bottom edges must change nothing.
    command_queue.push_back(make_cmd(OP_WRITE, 8'h41, 8'(COLUMNS), 8'd0, 8'h12));
    command_queue.push_back(make_cmd(OP_WRITE, 8'h42, 8'd0, 8'(ROWS), 8'h34));
    // Reads outside the screen return zeros.
    command_queue.push_back(make_cmd(OP_READ, any_byte(), 8'(COLUMNS), 8'd0, any_byte()));
    command_queue.push_back(make_cmd(OP_READ, 8'h00, 8'hFF, 8'hFF, 8'h00));
    // An out-of-range cursor position is ignored; then park in the corner.
    command_queue.push_back(make_cmd(OP_SET, any_byte(), 8'hFF, 8'hFF, any_byte()));
    command_queue.push_back(make_cmd(OP_SET, any_byte(), 8'(COLUMNS - 1), 8'(ROWS - 1),
                                     any_byte()));
    // Arrows against the right and bottom edges do nothing.
    command_queue.push_back(make_cmd(OP_ARROW, KEY_RIGHT, any_byte(), any_byte(), any_byte()));
    command_queue.push_back(make_cmd(OP_ARROW, KEY_DOWN, any_byte(), any_byte(), any_byte()));
    // Printing in the last cell wraps off the bottom and scrolls once.
    command_queue.push_back(make_cmd(OP_PRINT, 8'h41, any_byte(), any_byte(), any_byte()));
    command_queue.push_back(make_cmd(OP_READ, any_byte(), 8'(COLUMNS - 1), 8'(ROWS - 2),
                                     any_byte()));
    // Backspace at column zero steps back to the end of the previous row.
    command_queue.push_back(make_cmd(OP_BACKSPACE, any_byte(), any_byte(), any_byte(),
                                     any_byte()));
    // Two newlines: the first reaches the last row, the second scrolls.
    command_queue.push_back(make_cmd(OP_PRINT, NEWLINE_CODE, any_byte(), any_byte(),
                                     any_byte()));
    command_queue.push_back(make_cmd(OP_PRINT, NEWLINE_CODE, any_byte(), any_byte(),
                                     any_byte()));
    // A zero character is stored like any other.
    command_queue.push_back(make_cmd(OP_PRINT, 8'h00, any_byte(), any_byte(), any_byte()));
    command_queue.push_back(make_cmd(OP_UNUSED, any_byte(), any_byte(), any_byte(),
                                     any_byte()));
    // A scancode that is no arrow key is ignored.
    command_queue.push_back(make_cmd(OP_ARROW, 8'h00, any_byte(), any_byte(), any_byte()));
    command_queue.push_back(make_cmd(OP_CLEAR, any_byte(), any_byte(), any_byte(),
                                     any_byte()));
    // At the top-left corner backspace and the up and left arrows do nothing.
    command_queue.push_back(make_cmd(OP_BACKSPACE, any_byte(), any_byte(), any_byte(),
                                     any_byte()));
    command_queue.push_back(make_cmd(OP_ARROW, KEY_UP, any_byte(), any_byte(), any_byte()));
    command_queue.push_back(make_cmd(OP_ARROW, KEY_LEFT, any_byte(), any_byte(), any_byte()));
    command_queue.push_back(make_cmd(OP_ARROW, KEY_DOWN, any_byte(), any_byte(), any_byte()));
    command_queue.push_back(make_cmd(OP_ARROW, KEY_UP, any_byte(), any_byte(), any_byte()));
    play_commands();

    // Random phases, one per attribute setting. Most of the stimulus is
    // made of short, sensible runs: typing a line, editing with arrows and
    // backspace, writing cells and reading them back. The rest is noise.
    foreach (phase_attr[p]) begin
      write_attribute(phase_attr[p]);
      while (command_queue.size() < PHASE_ITEMS) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: begin
            // Type a line, often on the last rows so that wrapping and
            // newlines scroll the screen, then read back part of it.
            anchor_col = $urandom_range(0, COLUMNS - 1);
            anchor_row = $urandom_range(0, 1) ? ROWS - 1 - $urandom_range(0, 1)
                                               : $urandom_range(0, ROWS - 1);
            run_len = $urandom_range(3, 30);
            command_queue.push_back(make_cmd(OP_SET, any_byte(), 8'(anchor_col),
                                             8'(anchor_row), any_byte()));
            repeat (run_len) begin
              pick = $urandom_range(0, 11);
              if (pick == 0) begin
                ch = NEWLINE_CODE;
              end else if (pick == 1) begin
                ch = any_byte();
              end else begin
                ch = 8'($urandom_range(8'h21, 8'h7E));
              end
              command_queue.push_back(make_cmd(OP_PRINT, ch, any_byte(), any_byte(),
                                               any_byte()));
            end
            repeat ($urandom_range(1, 4)) begin
              command_queue.push_back(make_cmd(OP_READ, any_byte(),
                                               8'(anchor_col + $urandom_range(0, run_len)),
                                               8'(anchor_row - $urandom_range(0, 1)),
                                               any_byte()));
            end
          end
          7, 8, 9, 10: begin
            // Move around with the arrow keys and erase or overtype.
            command_queue.push_back(make_cmd(OP_SET, any_byte(), pick_coord(COLUMNS),
                                             pick_coord(ROWS), any_byte()));
            repeat ($urandom_range(3, 10)) begin
              case ($urandom_range(0, 5))
                0, 1, 2: begin
                  ch = ($urandom_range(0, 4) == 0) ? any_byte()
                                                    : arrow_keys[$urandom_range(0, 3)];
                  op = OP_ARROW;
                end
                3: begin
                  ch = any_byte();
                  op = OP_BACKSPACE;
                end
                default: begin
                  ch = 8'($urandom_range(8'h21, 8'h7E));
                  op = OP_PRINT;
                end
              endcase
              command_queue.push_back(make_cmd(op, ch, any_byte(), any_byte(), any_byte()));
            end
            repeat (2) begin
              command_queue.push_back(make_cmd(OP_READ, any_byte(), pick_coord(COLUMNS),
                                               pick_coord(ROWS), any_byte()));
            end
          end
          11, 12, 13, 14, 15: begin
            // Write a handful of cells, then read them back newest first.
            run_len = $urandom_range(1, 6);
            for (int i = 0; i < run_len; i++) begin
              spot_col[i] = pick_coord(COLUMNS);
              spot_row[i] = pick_coord(ROWS);
              command_queue.push_back(make_cmd(OP_WRITE, any_byte(), spot_col[i],
                                               spot_row[i], any_byte()));
            end
            for (int i = run_len - 1; i >= 0; i--) begin
              command_queue.push_back(make_cmd(OP_READ, any_byte(), spot_col[i],
                                               spot_row[i], any_byte()));
            end
          end
          default: begin
            // Noise: any operation with any fields. Clears are thinned out
            // since each one sweeps the whole buffer.
            repeat ($urandom_range(1, 4)) begin
              op = 3'($urandom_range(0, 7));
              if (op == OP_CLEAR && $urandom_range(0, 3) != 0) begin
                op = OP_READ;
              end
              command_queue.push_back(make_cmd(op, any_byte(), pick_coord(COLUMNS),
                                               pick_coord(ROWS), any_byte()));
            end
          end
        endcase
      end
      play_commands();
    end

    // Let every outstanding result arrive, then keep running before the verdict
    // so that a stray extra result would still be caught by the checker.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
